@@ src/lsb_stego_embed_extract_assert.svh @@
`ifndef LSB_STEGO_EMBED_EXTRACT_ASSERT_SVH
`define LSB_STEGO_EMBED_EXTRACT_ASSERT_SVH

// Check a property on every rising edge, off while reset is low
`define LSBSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define LSBSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lsbse_pkg.sv @@
package lsbse_pkg;

    // Default parameter values
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF  = 24;

    // Fixed field widths
    localparam int BYTE_BITS  = 8;
    localparam int MAX_K      = 16;
    localparam int K_W        = 5;
    localparam int PHASE_W    = 4;
    localparam int OFF_W      = 25;
    localparam int CNT_W      = 25;
    localparam int DIVD_W     = OFF_W + 3;
    localparam int SCOUNT_W   = 24;
    localparam int BUF_W      = 32;
    localparam int BUFCNT_W   = 6;
    localparam int ASMCNT_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Request types
    localparam logic [1:0] REQ_START   = 2'd0;
    localparam logic [1:0] REQ_SAMPLE  = 2'd1;
    localparam logic [1:0] REQ_PAYLOAD = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_SAMPLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT    = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_BAD_RANGE = 2'd1,
        STS_UNDERRUN  = 2'd2,
        STS_NO_XFER   = 2'd3
    } status_t;

    // Result fields of fixed width
    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 byte_valid;
        status_t              status;
        logic                 last;
    } res_info_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_OFF,
        S_WAIT_OFF,
        S_DIV_CNT,
        S_WAIT_CNT,
        S_CHECK
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic item;
        logic start_load;
        logic div_start;
        logic div_sel_cnt;
        logic save_first;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic room;
        logic req_start;
        logic div_done;
    } sts_t;

endpackage

@@ src/lsbse_if.sv @@
interface lsbse_req_if
    import lsbse_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             req_type;
    logic [OFF_W-1:0]       byte_offset;
    logic [CNT_W-1:0]       byte_count;
    logic [SAMPLE_BITS-1:0] carrier_sample;
    logic [BYTE_BITS-1:0]   payload_byte;

    modport source (output valid, req_type, byte_offset, byte_count, carrier_sample,
                    payload_byte, input ready);
    modport sink   (input valid, req_type, byte_offset, byte_count, carrier_sample,
                    payload_byte, output ready);
endinterface

interface lsbse_res_if
    import lsbse_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] out_sample;
    logic [INDEX_BITS-1:0]  sample_index;
    logic [BYTE_BITS-1:0]   out_byte;
    logic                   byte_valid;
    logic [1:0]             status;
    logic                   last;

    modport source (output valid, out_sample, sample_index, out_byte, byte_valid, status,
                    last, input ready);
    modport sink   (input valid, out_sample, sample_index, out_byte, byte_valid, status,
                    last, output ready);
endinterface

interface lsbse_cfg_if
    import lsbse_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/lsbse_div.sv @@
module lsbse_div
    import lsbse_pkg::*;
#(
    parameter int DIVIDEND_W = DIVD_W,
    parameter int DIVISOR_W  = K_W
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign fits      = rem_shift >= {1'b0, dsr_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = STEP_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next  = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operands
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ src/lsbse_ctrl.sv @@
`include "lsb_stego_embed_extract_assert.svh"

module lsbse_ctrl
    import lsbse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        in_fire;

    assign in_fire = in_valid && in_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && sts.req_start)
                begin
                    state_next = S_DIV_OFF;
                end
            end
            S_DIV_OFF:
            begin
                state_next = S_WAIT_OFF;
            end
            S_WAIT_OFF:
            begin
                if (sts.div_done)
                begin
                    state_next = S_DIV_CNT;
                end
            end
            S_DIV_CNT:
            begin
                state_next = S_WAIT_CNT;
            end
            S_WAIT_CNT:
            begin
                if (sts.div_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready       = sts.room;
                cmd.item       = in_valid && sts.room && !sts.req_start;
                cmd.start_load = in_valid && sts.room && sts.req_start;
            end
            S_DIV_OFF:
            begin
                cmd.div_start = 1'b1;
            end
            S_WAIT_OFF:
            begin
                cmd.save_first = sts.div_done;
            end
            S_DIV_CNT:
            begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_cnt = 1'b1;
            end
            S_CHECK:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `LSBSE_ASSERT_NEXT(a_start_divides, clk, rst_n,
        in_fire && sts.req_start, state_reg == S_DIV_OFF,
        "start word did not launch the divider")
    `LSBSE_ASSERT(a_done_when_waiting, clk, rst_n,
        sts.div_done |-> (state_reg == S_WAIT_OFF || state_reg == S_WAIT_CNT),
        "divider finished outside a wait state")
    `LSBSE_ASSERT(a_check_has_room, clk, rst_n,
        (state_reg == S_CHECK) |-> sts.room,
        "no result room when closing a start")

endmodule

@@ src/lsbse_datapath.sv @@
`include "lsb_stego_embed_extract_assert.svh"

module lsbse_datapath
    import lsbse_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             req_type,
    input  logic [OFF_W-1:0]       byte_offset,
    input  logic [CNT_W-1:0]       byte_count,
    input  logic [SAMPLE_BITS-1:0] carrier_sample,
    input  logic [BYTE_BITS-1:0]   payload_byte,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    lsbse_res_if.source            res,
    lsbse_cfg_if.sink              cfg
);

    localparam int K_LIMIT    = (SAMPLE_BITS < MAX_K) ? SAMPLE_BITS : MAX_K;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = PTR_W + 1;

    // Configuration
    logic [K_W-1:0]      k_cfg_reg;
    logic                dir_reg;
    logic [SCOUNT_W-1:0] scount_reg;

    // Transfer state
    logic                  active_reg, active_next;
    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [INDEX_BITS-1:0] index_reg, index_next;
    logic [CNT_W-1:0]      remain_reg, remain_next;
    logic [BUF_W-1:0]      buf_reg, buf_next;
    logic [BUFCNT_W-1:0]   bufcnt_reg, bufcnt_next;
    logic [BYTE_BITS-1:0]  asm_reg, asm_next;
    logic [ASMCNT_W-1:0]   asmcnt_reg, asmcnt_next;

    // Start item operands and first quotient
    logic [OFF_W-1:0]   off_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIVD_W-1:0]  first_reg;
    logic [PHASE_W-1:0] ph_first_reg;

    // Divider
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVD_W-1:0] div_quo;
    logic [K_W-1:0]    div_rem;
    logic              div_done;

    // Result queue
    logic [SAMPLE_BITS-1:0] f_sample [FIFO_DEPTH];
    logic [INDEX_BITS-1:0]  f_index  [FIFO_DEPTH];
    res_info_t              f_info   [FIFO_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg, wr_ptr_p1;
    logic [FCNT_W-1:0]      fifo_cnt_reg;
    logic                   pop;
    logic [1:0]             push_cnt;
    logic [SAMPLE_BITS-1:0] w_sample [2];
    logic [INDEX_BITS-1:0]  w_index  [2];
    res_info_t              w_info   [2];

    // Per-sample working values
    logic [K_W-1:0]      k_eff;
    logic [PHASE_W-1:0]  ph;
    logic [K_W-1:0]      avail;
    logic [K_W-1:0]      rem_bits;
    logic [K_W-1:0]      take;
    logic [BUF_W-1:0]    s_shift;
    logic [BUF_W-1:0]    take_mask;
    logic [23:0]         joined;
    logic [K_W-1:0]      tot_bits;
    logic [1:0]          nbytes;
    logic [K_W-1:0]      x_ph_sum;
    logic [CNT_W-1:0]    x_remain;
    logic [BUFCNT_W-1:0] total_cap;
    logic [K_W-1:0]      n_emb;
    logic                under;
    logic [BUF_W-1:0]    emask;
    logic [BUF_W-1:0]    emb_s;
    logic [K_W-1:0]      e_ph_sum;
    logic                emb_last;
    logic [DIVD_W:0]     range_sum;
    logic                range_bad;

    // Clamp bits per sample to the usable range
    assign k_eff = (k_cfg_reg == '0) ? K_W'(1)
                 : ((k_cfg_reg > K_W'(K_LIMIT)) ? K_W'(K_LIMIT) : k_cfg_reg);
    assign ph    = ({1'b0, phase_reg} < k_eff) ? phase_reg : '0;
    assign avail = k_eff - {1'b0, ph};

    // Extract: bits taken from this sample and bytes completed
    always_comb
    begin
        if (remain_reg == '0)
        begin
            rem_bits = '0;
        end
        else if (remain_reg >= CNT_W'(3))
        begin
            rem_bits = K_W'(3 * BYTE_BITS);
        end
        else
        begin
            rem_bits = {remain_reg[1:0], 3'b000} - {2'b00, asmcnt_reg};
        end
    end

    assign take      = (avail < rem_bits) ? avail : rem_bits;
    assign s_shift   = BUF_W'(carrier_sample) >> ph;
    assign take_mask = (BUF_W'(1) << take) - BUF_W'(1);
    assign joined    = {16'b0, asm_reg} | (24'(s_shift & take_mask) << asmcnt_reg);
    assign tot_bits  = {2'b00, asmcnt_reg} + take;
    assign nbytes    = tot_bits[4:3];
    assign x_ph_sum  = {1'b0, ph} + take;
    assign x_remain  = remain_reg - CNT_W'(nbytes);

    // Embed: bits this sample needs, capped by what is left to send
    assign total_cap = (remain_reg >= CNT_W'(4)) ? '1
                     : bufcnt_reg + {1'b0, remain_reg[1:0], 3'b000};
    assign n_emb     = ({1'b0, avail} > total_cap) ? total_cap[K_W-1:0] : avail;
    assign under     = {1'b0, n_emb} > bufcnt_reg;
    assign emask     = (BUF_W'(1) << n_emb) - BUF_W'(1);
    assign emb_s     = (BUF_W'(carrier_sample) & ~(emask << ph)) | ((buf_reg & emask) << ph);
    assign e_ph_sum  = {1'b0, ph} + n_emb;
    assign emb_last  = total_cap == {1'b0, n_emb};

    // Range check of a start item
    assign range_sum = {1'b0, first_reg} + {1'b0, div_quo};
    assign range_bad = (cnt_reg == '0) || (range_sum >= (DIVD_W + 1)'(scount_reg));

    assign div_dividend = cmd.div_sel_cnt ? {cnt_reg, 3'b000} : {off_reg, 3'b000};

    lsbse_div #(
        .DIVIDEND_W (DIVD_W),
        .DIVISOR_W  (K_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (k_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // State update and result words
    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        index_next  = index_reg;
        remain_next = remain_reg;
        buf_next    = buf_reg;
        bufcnt_next = bufcnt_reg;
        asm_next    = asm_reg;
        asmcnt_next = asmcnt_reg;
        push_cnt    = 2'd0;
        w_sample[0] = '0;
        w_sample[1] = '0;
        w_index[0]  = '0;
        w_index[1]  = '0;
        w_info[0]   = '0;
        w_info[1]   = '0;

        if (cmd.start_load)
        begin
            buf_next    = '0;
            bufcnt_next = '0;
            asm_next    = '0;
            asmcnt_next = '0;
        end

        if (cmd.finish)
        begin
            push_cnt = 2'd1;
            if (range_bad)
            begin
                active_next      = 1'b0;
                remain_next      = '0;
                w_info[0].status = STS_BAD_RANGE;
                w_info[0].last   = 1'b1;
            end
            else
            begin
                active_next = 1'b1;
                phase_next  = ph_first_reg;
                index_next  = INDEX_BITS'(first_reg);
                remain_next = cnt_reg;
                w_index[0]  = INDEX_BITS'(first_reg);
            end
        end

        if (cmd.item)
        begin
            case (req_type)
                REQ_SAMPLE:
                begin
                    push_cnt = 2'd1;
                    if (!active_reg)
                    begin
                        w_info[0].status = STS_NO_XFER;
                    end
                    else if (!dir_reg)
                    begin
                        // Extract: emit completed bytes, keep the partial one
                        w_index[0]  = index_reg;
                        w_index[1]  = index_reg;
                        remain_next = x_remain;
                        active_next = x_remain != '0;
                        asmcnt_next = tot_bits[2:0];
                        if (x_ph_sum >= k_eff)
                        begin
                            phase_next = '0;
                            index_next = index_reg + INDEX_BITS'(1);
                        end
                        else
                        begin
                            phase_next = x_ph_sum[PHASE_W-1:0];
                        end
                        case (nbytes)
                            2'd0:
                            begin
                                asm_next       = joined[7:0];
                                w_info[0].last = remain_reg == '0;
                            end
                            2'd1:
                            begin
                                asm_next = joined[15:8];
                            end
                            default:
                            begin
                                push_cnt = 2'd2;
                                asm_next = joined[23:16];
                            end
                        endcase
                        if (nbytes != 2'd0)
                        begin
                            w_info[0].data_byte  = joined[7:0];
                            w_info[0].byte_valid = 1'b1;
                            w_info[0].last       = remain_reg == CNT_W'(1);
                            w_info[1].data_byte  = joined[15:8];
                            w_info[1].byte_valid = 1'b1;
                            w_info[1].last       = remain_reg == CNT_W'(2);
                        end
                    end
                    else
                    begin
                        // Embed: replace the low bits from the bit buffer
                        w_sample[0] = carrier_sample;
                        w_index[0]  = index_reg;
                        if (bufcnt_reg == '0 && remain_reg == '0)
                        begin
                            active_next    = 1'b0;
                            w_info[0].last = 1'b1;
                        end
                        else if (under)
                        begin
                            w_info[0].status = STS_UNDERRUN;
                        end
                        else
                        begin
                            w_sample[0]    = SAMPLE_BITS'(emb_s);
                            buf_next       = buf_reg >> n_emb;
                            bufcnt_next    = bufcnt_reg - BUFCNT_W'(n_emb);
                            active_next    = !emb_last;
                            w_info[0].last = emb_last;
                            if (e_ph_sum >= k_eff)
                            begin
                                phase_next = '0;
                                index_next = index_reg + INDEX_BITS'(1);
                            end
                            else
                            begin
                                phase_next = e_ph_sum[PHASE_W-1:0];
                            end
                        end
                    end
                end
                REQ_PAYLOAD:
                begin
                    if (!active_reg)
                    begin
                        push_cnt         = 2'd1;
                        w_info[0].status = STS_NO_XFER;
                    end
                    else if (dir_reg && remain_reg != '0
                             && bufcnt_reg <= BUFCNT_W'(BUF_W - BYTE_BITS))
                    begin
                        // Queue the byte above the bits already held
                        buf_next    = buf_reg | (BUF_W'(payload_byte) << bufcnt_reg);
                        bufcnt_next = bufcnt_reg + BUFCNT_W'(BYTE_BITS);
                        remain_next = remain_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    push_cnt = 2'd0;
                end
            endcase
        end
    end

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_cfg_reg  <= K_W'(1);
            dir_reg    <= 1'b0;
            scount_reg <= '1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_BITS_PER_SAMPLE: k_cfg_reg  <= cfg.data[K_W-1:0];
                CFG_DIRECTION:       dir_reg    <= cfg.data[0];
                CFG_SAMPLE_COUNT:    scount_reg <= cfg.data[SCOUNT_W-1:0];
                default:             k_cfg_reg  <= k_cfg_reg;
            endcase
        end
    end

    // Transfer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= '0;
            index_reg  <= '0;
            remain_reg <= '0;
            buf_reg    <= '0;
            bufcnt_reg <= '0;
            asm_reg    <= '0;
            asmcnt_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            remain_reg <= remain_next;
            buf_reg    <= buf_next;
            bufcnt_reg <= bufcnt_next;
            asm_reg    <= asm_next;
            asmcnt_reg <= asmcnt_next;
        end
    end

    // Hold start operands and the first quotient
    always_ff @(posedge clk)
    begin
        if (cmd.start_load)
        begin
            off_reg <= byte_offset;
            cnt_reg <= byte_count;
        end
        if (cmd.save_first)
        begin
            first_reg    <= div_quo;
            ph_first_reg <= div_rem[PHASE_W-1:0];
        end
    end

    // Result queue
    assign wr_ptr_p1     = wr_ptr_reg + PTR_W'(1);
    assign pop           = res.valid && res.ready;
    assign sts.room      = fifo_cnt_reg <= FCNT_W'(FIFO_DEPTH - 2);
    assign sts.req_start = req_type == REQ_START;
    assign sts.div_done  = div_done;

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            f_sample[wr_ptr_reg] <= w_sample[0];
            f_index[wr_ptr_reg]  <= w_index[0];
            f_info[wr_ptr_reg]   <= w_info[0];
        end
        if (push_cnt == 2'd2)
        begin
            f_sample[wr_ptr_p1] <= w_sample[1];
            f_index[wr_ptr_p1]  <= w_index[1];
            f_info[wr_ptr_p1]   <= w_info[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_reg + PTR_W'(push_cnt);
            rd_ptr_reg   <= rd_ptr_reg + PTR_W'(pop);
            fifo_cnt_reg <= fifo_cnt_reg + FCNT_W'(push_cnt) - FCNT_W'(pop);
        end
    end

    // Drive the head word
    assign res.valid        = fifo_cnt_reg != '0;
    assign res.out_sample   = f_sample[rd_ptr_reg];
    assign res.sample_index = f_index[rd_ptr_reg];
    assign res.out_byte     = f_info[rd_ptr_reg].data_byte;
    assign res.byte_valid   = f_info[rd_ptr_reg].byte_valid;
    assign res.status       = f_info[rd_ptr_reg].status;
    assign res.last         = f_info[rd_ptr_reg].last;

    `LSBSE_ASSERT(a_queue_fits, clk, rst_n, (push_cnt != 2'd0) |-> (({1'b0, fifo_cnt_reg} + (FCNT_W + 1)'(push_cnt)) <= (FCNT_W + 1)'(FIFO_DEPTH)), "result queue overrun")
    `LSBSE_ASSERT_NEXT(a_underrun_holds, clk, rst_n, push_cnt != 2'd0 && w_info[0].status == STS_UNDERRUN, $stable(bufcnt_reg) && $stable(phase_reg) && $stable(index_reg), "underrun moved the transfer state")
    `LSBSE_ASSERT(a_buffer_bound, clk, rst_n, bufcnt_reg <= BUFCNT_W'(BUF_W), "bit buffer count past its width")

endmodule

@@ src/lsb_stego_embed_extract.sv @@
// Channel  Dir  Handshake      Carries
// req      in   valid/ready    req_type, byte_offset, byte_count, carrier_sample, payload_byte
// res      out  valid/ready    out_sample, sample_index, out_byte, byte_valid, status, last
// cfg      in   valid/ready    index, data (always ready)
//
// Sample and payload words take one cycle each and are accepted back to back while the
// four-entry result queue holds at most two words.
// Once accepted, a start word makes two passes through the one-bit-per-cycle divider
// (first sample from bit offset over k, then bit count over k), each with a load and a
// done step, and then a range check.
// Reset clears the transfer state and the queue; configuration returns to k = 1,
// extract, full sample count. A stalled res holds its word and stops intake once three
// words wait.
module lsb_stego_embed_extract
    import lsbse_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    lsbse_req_if.sink   req,
    lsbse_res_if.source res,
    lsbse_cfg_if.sink   cfg
);

    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    assign req.ready = in_ready;

    lsbse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lsbse_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_type       (req.req_type),
        .byte_offset    (req.byte_offset),
        .byte_count     (req.byte_count),
        .carrier_sample (req.carrier_sample),
        .payload_byte   (req.payload_byte),
        .cmd            (cmd),
        .sts            (sts),
        .res            (res),
        .cfg            (cfg)
    );

endmodule
